// ===== hdl/mh64_pkg.sv =====
// Shared constants, command codes and control structs for the MurmurHash64A engine.
`timescale 1ns / 1ps

package mh64_pkg;

    // Mixing multiplier, split into halves for the 32x32 multiply unit.
    localparam logic [63:0] MIX_MUL    = 64'hC6A4A7935BD1E995;
    localparam logic [31:0] MIX_MUL_LO = MIX_MUL[31:0];
    localparam logic [31:0] MIX_MUL_HI = MIX_MUL[63:32];
    localparam int unsigned MIX_SHIFT  = 47;

    // Input and output field widths.
    localparam int unsigned WORD_W     = 64;
    localparam int unsigned NBYTES_W   = 4;
    localparam int unsigned LEN_W      = 32;
    localparam int unsigned UPPER_W    = 32;
    localparam int unsigned S_TDATA_W  = 104;
    localparam int unsigned M_TDATA_W  = 96;

    // Operand register load selection.
    localparam logic [2:0] OP_HOLD  = 3'd0;
    localparam logic [2:0] OP_LEN   = 3'd1;
    localparam logic [2:0] OP_WORD  = 3'd2;
    localparam logic [2:0] OP_KMIX  = 3'd3;
    localparam logic [2:0] OP_HACC  = 3'd4;
    localparam logic [2:0] OP_HTAIL = 3'd5;
    localparam logic [2:0] OP_HFIN  = 3'd6;

    // Running hash load selection.
    localparam logic [1:0] H_HOLD = 2'd0;
    localparam logic [1:0] H_SEED = 2'd1;
    localparam logic [1:0] H_ACC  = 2'd2;

    // Partial product phases of one 64-bit multiply by MIX_MUL.
    localparam logic [1:0] MUL_LO    = 2'd0;
    localparam logic [1:0] MUL_HI    = 2'd1;
    localparam logic [1:0] MUL_CROSS = 2'd2;

    typedef struct packed {
        logic       load_in;
        logic [2:0] op_sel;
        logic [1:0] h_sel;
        logic       mul_en;
        logic [1:0] mul_phase;
        logic       out_load;
    } mh64_cmd_t;

    typedef struct packed {
        logic full_word;
        logic tail_word;
        logic last_word;
        logic out_free;
    } mh64_status_t;

endpackage

// ===== hdl/mh64_datapath.sv =====
// Datapath: input capture, operand and running hash registers, shared multiplier, output stage.
`timescale 1ns / 1ps

module mh64_datapath
    import mh64_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mh64_cmd_t            cmd,
    output mh64_status_t         status,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    input  logic                 seed_wr_en,
    input  logic [WORD_W-1:0]    seed_wr_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [WORD_W-1:0]   word_reg;
    logic [NBYTES_W-1:0] nbytes_reg;
    logic                last_reg;
    logic [WORD_W-1:0]   op_reg;
    logic [WORD_W-1:0]   op_next;
    logic [WORD_W-1:0]   acc_reg;
    logic [WORD_W-1:0]   acc_next;
    logic [WORD_W-1:0]   h_reg;
    logic [WORD_W-1:0]   h_next;
    logic [WORD_W-1:0]   seed_reg;
    logic [WORD_W-1:0]   hash_reg;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         mul_prod;
    logic [WORD_W-1:0]   tail_mask;
    logic [WORD_W-1:0]   in_length_ext;

    assign in_length_ext = {{(WORD_W-LEN_W){1'b0}}, s_tdata[99:68]};

    // Byte i of a tail survives when i is below the valid byte count.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            tail_mask[8*i +: 8] = (4'(i) < nbytes_reg) ? 8'hFF : 8'h00;
        end
    end

    // One 32x32 multiplier; a 64-bit product modulo 2^64 takes three phases.
    assign mul_a    = (cmd.mul_phase == MUL_HI) ? op_reg[63:32] : op_reg[31:0];
    assign mul_b    = (cmd.mul_phase == MUL_CROSS) ? MIX_MUL_HI : MIX_MUL_LO;
    assign mul_prod = 64'(mul_a) * 64'(mul_b);

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.mul_en)
        begin
            if (cmd.mul_phase == MUL_LO)
            begin
                acc_next = mul_prod;
            end
            else
            begin
                acc_next = {acc_reg[63:32] + mul_prod[31:0], acc_reg[31:0]};
            end
        end
    end

    always_comb
    begin
        unique case (cmd.op_sel)
            OP_LEN:   op_next = in_length_ext;
            OP_WORD:  op_next = word_reg;
            OP_KMIX:  op_next = acc_reg ^ (acc_reg >> MIX_SHIFT);
            OP_HACC:  op_next = h_reg ^ acc_reg;
            OP_HTAIL: op_next = h_reg ^ (word_reg & tail_mask);
            OP_HFIN:  op_next = h_reg ^ (h_reg >> MIX_SHIFT);
            default:  op_next = op_reg;
        endcase
    end

    always_comb
    begin
        unique case (cmd.h_sel)
            H_SEED:  h_next = seed_reg ^ acc_reg;
            H_ACC:   h_next = acc_reg;
            default: h_next = h_reg;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (seed_wr_en)
            begin
                seed_reg <= seed_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            word_reg   <= s_tdata[63:0];
            nbytes_reg <= s_tdata[67:64];
            last_reg   <= s_tlast;
        end
        if (cmd.out_load)
        begin
            hash_reg <= acc_reg ^ (acc_reg >> MIX_SHIFT);
        end
        op_reg  <= op_next;
        acc_reg <= acc_next;
        h_reg   <= h_next;
    end

    // Byte counts of eight and above count as a full word.
    assign status.full_word = nbytes_reg[3];
    assign status.tail_word = !nbytes_reg[3] && (nbytes_reg[2:0] != 3'd0);
    assign status.last_word = last_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {hash_reg[63:32], hash_reg};

endmodule

// ===== hdl/mh64_ctrl.sv =====
// Controller state machine that sequences seeding, word mixing, tail folding and finalization.
`timescale 1ns / 1ps

module mh64_ctrl
    import mh64_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  mh64_status_t status,
    output mh64_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SEED_M = 4'd1;
    localparam logic [3:0] ST_SEED_W = 4'd2;
    localparam logic [3:0] ST_DISP   = 4'd3;
    localparam logic [3:0] ST_K1_M   = 4'd4;
    localparam logic [3:0] ST_K1_W   = 4'd5;
    localparam logic [3:0] ST_K2_M   = 4'd6;
    localparam logic [3:0] ST_K2_W   = 4'd7;
    localparam logic [3:0] ST_H_M    = 4'd8;
    localparam logic [3:0] ST_H_W    = 4'd9;
    localparam logic [3:0] ST_FIN_P  = 4'd10;
    localparam logic [3:0] ST_FIN_M  = 4'd11;
    localparam logic [3:0] ST_FIN_W  = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic       in_msg_reg;
    logic       in_msg_next;
    logic       mul_done;

    assign mul_done = (phase_reg == MUL_CROSS);

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        in_msg_next   = in_msg_reg;
        s_tready      = 1'b0;
        cmd           = '0;
        cmd.op_sel    = OP_HOLD;
        cmd.h_sel     = H_HOLD;
        cmd.mul_phase = phase_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    if (!in_msg_reg)
                    begin
                        // First transaction of a message: the length seeds the hash.
                        cmd.op_sel  = OP_LEN;
                        in_msg_next = 1'b1;
                        state_next  = ST_SEED_M;
                    end
                    else
                    begin
                        state_next = ST_DISP;
                    end
                end
            end
            ST_SEED_M, ST_K1_M, ST_K2_M, ST_H_M, ST_FIN_M:
            begin
                cmd.mul_en = 1'b1;
                if (mul_done)
                begin
                    phase_next = MUL_LO;
                    state_next = state_reg + 4'd1;
                end
                else
                begin
                    phase_next = phase_reg + 2'd1;
                end
            end
            ST_SEED_W:
            begin
                cmd.h_sel  = H_SEED;
                state_next = ST_DISP;
            end
            ST_DISP:
            begin
                if (status.full_word)
                begin
                    cmd.op_sel = OP_WORD;
                    state_next = ST_K1_M;
                end
                else if (status.tail_word)
                begin
                    cmd.op_sel = OP_HTAIL;
                    state_next = ST_H_M;
                end
                else if (status.last_word)
                begin
                    state_next = ST_FIN_P;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_K1_W:
            begin
                cmd.op_sel = OP_KMIX;
                state_next = ST_K2_M;
            end
            ST_K2_W:
            begin
                cmd.op_sel = OP_HACC;
                state_next = ST_H_M;
            end
            ST_H_W:
            begin
                cmd.h_sel  = H_ACC;
                state_next = status.last_word ? ST_FIN_P : ST_IDLE;
            end
            ST_FIN_P:
            begin
                cmd.op_sel = OP_HFIN;
                state_next = ST_FIN_M;
            end
            ST_FIN_W:
            begin
                // Hold here until the output register can take the result.
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    in_msg_next  = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                phase_next = MUL_LO;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= MUL_LO;
            in_msg_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            in_msg_reg <= in_msg_next;
        end
    end

endmodule

// ===== hdl/murmur64a_hash_engine.sv =====
// Top level: each 64-bit multiply runs as three phases on one shared 32x32 multiplier.
// Per transaction: an empty word needs no multiply, a tail word one hash multiply, a full word
// two key-mixing multiplies and the hash multiply; a message's first transaction adds seeding.
// The last adds finalization, which waits for a free output register before loading the hash.
// rst_n clears the controller, the output valid and the seed register (seed reads as zero).
`timescale 1ns / 1ps

module murmur64a_hash_engine
    import mh64_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 seed_wr_en,
    input  logic [WORD_W-1:0]    seed_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // data_word[63:0], valid_bytes[67:64], message_length[99:68], zero[103:100]
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // hash_value[63:0], hash_upper[95:64]
    output logic [M_TDATA_W-1:0] m_tdata
);

    mh64_cmd_t    cmd;
    mh64_status_t status;

    mh64_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mh64_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .seed_wr_en   (seed_wr_en),
        .seed_wr_data (seed_wr_data),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the MurmurHash64A engine: stream stimulus and a hash predictor.
`timescale 1ns / 1ps

module testbench;
    import mh64_pkg::*;

    typedef struct {
        logic [63:0] hash;
        logic [31:0] upper;
    } digest_t;

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 seed_wr_en   = 1'b0;
    logic [WORD_W-1:0]    seed_wr_data = '0;
    logic                 s_tvalid     = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata      = '0;
    logic                 s_tlast      = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready     = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Predictor state: seed register, running hash and whether a message is open.
    logic [63:0] seed_reg = '0;
    logic [63:0] run_hash = '0;
    logic        msg_open = 1'b0;
    digest_t     pending_digests[$];

    bit send_gaps_en  = 1'b1;
    bit sink_stall_en = 1'b1;
    int mismatch_count  = 0;
    int digests_checked = 0;
    int items_sent      = 0;
    int msgs_sent       = 0;
    int seed_settings   = 1;

    murmur64a_hash_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .seed_wr_en   (seed_wr_en),
        .seed_wr_data (seed_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 1000000);
        $display("Timeout: the engine stopped making progress.");
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        m_tready <= sink_stall_en ? ($urandom_range(99) >= 23) : 1'b1;
    end

    // Compare each output transaction with the oldest predicted digest.
    always @(posedge clk)
    begin
        digest_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_digests.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected hash output %h", m_tdata);
            end
            else
            begin
                want = pending_digests.pop_front();
                digests_checked++;
                if (m_tdata[63:0] !== want.hash || m_tdata[95:64] !== want.upper)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Hash mismatch: expected %h/%h, got %h/%h",
                                 want.hash, want.upper, m_tdata[63:0], m_tdata[95:64]);
                end
            end
        end
    end

    function automatic logic [63:0] mix_key(input logic [63:0] key);
        logic [63:0] k;
        k = key * MIX_MUL;
        k = k ^ (k >> MIX_SHIFT);
        k = k * MIX_MUL;
        return k;
    endfunction

    // Fold one accepted word into the running hash; finalize on the last word.
    function automatic void fold_word(input logic [63:0] word, input logic [3:0] nbytes,
                                      input logic last, input logic [31:0] len);
        logic [63:0] h;
        logic [63:0] mask;
        digest_t     d;
        if (!msg_open)
        begin
            run_hash = seed_reg ^ (64'(len) * MIX_MUL);
            msg_open = 1'b1;
        end
        h = run_hash;
        if (nbytes >= 4'd8)
            h = (h ^ mix_key(word)) * MIX_MUL;
        else if (nbytes != 4'd0)
        begin
            mask = (64'd1 << (8 * nbytes)) - 64'd1;
            h = (h ^ (word & mask)) * MIX_MUL;
        end
        run_hash = h;
        if (last)
        begin
            h = h ^ (h >> MIX_SHIFT);
            h = h * MIX_MUL;
            h = h ^ (h >> MIX_SHIFT);
            d.hash  = h;
            d.upper = h[63:32];
            pending_digests.push_back(d);
            run_hash = '0;
            msg_open = 1'b0;
        end
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is accepted.
    task automatic send_word(input logic [63:0] word, input logic [3:0] nbytes,
                             input logic last, input logic [31:0] len);
        if (send_gaps_en && $urandom_range(99) < 23)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, len, nbytes, word};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        fold_word(word, nbytes, last, len);
        items_sent++;
        if (last)
            msgs_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_digests.size() != 0)
            @(posedge clk);
        // A word that ends no message may still be in the multiplier.
        repeat (40) @(posedge clk);
    endtask

    task automatic set_seed(input logic [63:0] value);
        wait_idle();
        seed_wr_en   <= 1'b1;
        seed_wr_data <= value;
        @(posedge clk);
        seed_wr_en <= 1'b0;
        seed_reg = value;
        seed_settings++;
    endtask

    // Well-formed message: full words, then a tail or an empty closing word unless the last full word closes it.
    task automatic send_message(input int total, input logic [31:0] len);
        int  nfull;
        int  rem;
        bit  empty_end;
        logic [3:0] nb;
        nfull = total / 8;
        rem = total % 8;
        empty_end = (nfull == 0) || ($urandom_range(1) == 1);
        for (int i = 0; i < nfull; i++)
        begin
            nb = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'd8;
            send_word(rand_word(), nb, (rem == 0) && !empty_end && (i == nfull - 1), len);
        end
        if (rem != 0)
            send_word(rand_word(), 4'(rem), 1'b1, len);
        else if (empty_end)
            send_word(rand_word(), 4'd0, 1'b1, len);
    endtask

    task automatic test_corner_cases();
        send_word(64'd0, 4'd0, 1'b1, 32'd0);
        send_word({64{1'b1}}, 4'd8, 1'b1, 32'd8);
        send_word({64{1'b1}}, 4'd1, 1'b1, 32'd1);
        send_word(64'h0123456789ABCDEF, 4'd7, 1'b1, 32'd7);
        // Oversized byte count with a length that does not match.
        send_word(64'hFEDCBA9876543210, 4'd15, 1'b1, 32'hFFFFFFFF);
        send_word(64'h1111111111111111, 4'd8, 1'b0, 32'd16);
        send_word(64'h2222222222222222, 4'd8, 1'b0, 32'd16);
        send_word(64'd0, 4'd0, 1'b1, 32'd16);
        // A partial word in the middle of a message is folded as a tail.
        send_word(64'hA5A5A5A5A5A5A5A5, 4'd3, 1'b0, 32'd11);
        send_word(64'h5A5A5A5A5A5A5A5A, 4'd8, 1'b1, 32'd11);
        send_word(64'd0, 4'd8, 1'b1, 32'd0);
        set_seed({64{1'b1}});
        send_word(64'd0, 4'd0, 1'b1, 32'hFFFFFFFF);
        send_word(64'hAAAAAAAAAAAAAAAA, 4'd8, 1'b1, 32'd8);
        send_word(64'h5555555555555555, 4'd9, 1'b0, 32'd12);
        send_word({64{1'b1}}, 4'd4, 1'b1, 32'd12);
        send_word(64'h8000000000000001, 4'd8, 1'b1, 32'h80000000);
    endtask

    task automatic test_random_messages(input int budget);
        int stop_at;
        int total;
        logic [31:0] len;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            total = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(40);
            len = ($urandom_range(9) == 0) ? 32'($urandom) : 32'(total);
            send_message(total, len);
        end
    endtask

    // Broken sequences: any byte count on any word, random lengths.
    task automatic test_noise_sequences(input int budget);
        int stop_at;
        int n;
        logic [31:0] len;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            n = $urandom_range(6, 1);
            len = 32'($urandom);
            for (int i = 0; i < n; i++)
                send_word(rand_word(), 4'($urandom_range(15)), i == n - 1, len);
        end
    endtask

    task automatic test_back_to_back(input int budget);
        wait_idle();
        send_gaps_en  = 1'b0;
        sink_stall_en <= 1'b0;
        test_random_messages(budget);
        wait_idle();
        send_gaps_en  = 1'b1;
        sink_stall_en <= 1'b1;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_cases();
        set_seed(rand_word());
        test_random_messages(500);
        set_seed(64'd0);
        test_random_messages(300);
        set_seed({64{1'b1}});
        test_noise_sequences(250);
        set_seed(rand_word());
        test_back_to_back(350);
        wait_idle();

        $display("Sent %0d words in %0d messages under %0d seed settings.",
                 items_sent, msgs_sent, seed_settings);
        $display("Checked %0d hashes, %0d mismatches.", digests_checked, mismatch_count);
        if (mismatch_count == 0 && pending_digests.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/mh64_pkg.sv
hdl/mh64_datapath.sv
hdl/mh64_ctrl.sv
hdl/murmur64a_hash_engine.sv
tb/sv/testbench.sv
